// ----- hdl/rbs_pkg.sv -----
// Shared types and constants for the ray against box slab test.
// Depends on nothing; rbs_front, rbs_back, the top level and the checker import it.
package rbs_pkg;

	localparam int FIELD_BITS = 32;
	localparam int DIST_BITS = 31;
	localparam logic [DIST_BITS-1:0] ENTRY_MAX = '1;

	// One ray and one box, all signed fixed point.
	typedef struct packed {
		logic signed [FIELD_BITS-1:0] origin_x;
		logic signed [FIELD_BITS-1:0] origin_y;
		logic signed [FIELD_BITS-1:0] origin_z;
		logic signed [FIELD_BITS-1:0] direction_x;
		logic signed [FIELD_BITS-1:0] direction_y;
		logic signed [FIELD_BITS-1:0] direction_z;
		logic signed [FIELD_BITS-1:0] box_low_x;
		logic signed [FIELD_BITS-1:0] box_low_y;
		logic signed [FIELD_BITS-1:0] box_low_z;
		logic signed [FIELD_BITS-1:0] box_high_x;
		logic signed [FIELD_BITS-1:0] box_high_y;
		logic signed [FIELD_BITS-1:0] box_high_z;
	} ray_t;

	typedef struct packed {
		logic                 hit;
		logic [DIST_BITS-1:0] entry_distance;
	} result_t;

	// Width of one classified axis as it travels from the front to the back.
	function automatic int slab_bits(int coord_bits);
		return 3 * coord_bits + 7;
	endfunction

endpackage

// ----- hdl/rbs_front.sv -----
// Front end: narrows the coordinates, forms slab offsets and magnitudes and
// classifies parallel axes. Depends on rbs_pkg.
module rbs_front #(
	parameter int COORD_BITS = 32
) (
	input  rbs_pkg::ray_t                                   ray,
	output logic [3*rbs_pkg::slab_bits(COORD_BITS)-1:0]     slab
);
	import rbs_pkg::*;

	localparam int MW = COORD_BITS + 1;

	typedef struct packed {
		logic                  par;
		logic                  pmiss;
		logic                  dneg;
		logic                  neg_lo;
		logic                  neg_hi;
		logic [MW-1:0]         amag_lo;
		logic [MW-1:0]         amag_hi;
		logic [COORD_BITS-1:0] dmag;
	} slab_t;

	slab_t [2:0] ax;
	logic [2:0][FIELD_BITS-1:0] o_f, d_f, l_f, h_f;

	// Only the low COORD_BITS bits of a field count; above 32 bits it is zero extended.
	function automatic logic signed [COORD_BITS-1:0] coord(logic [FIELD_BITS-1:0] f);
		logic [COORD_BITS+FIELD_BITS-1:0] e;
		e = {{COORD_BITS{1'b0}}, f};
		return e[COORD_BITS-1:0];
	endfunction

	assign o_f = {ray.origin_z, ray.origin_y, ray.origin_x};
	assign d_f = {ray.direction_z, ray.direction_y, ray.direction_x};
	assign l_f = {ray.box_low_z, ray.box_low_y, ray.box_low_x};
	assign h_f = {ray.box_high_z, ray.box_high_y, ray.box_high_x};

	// Per axis: exact offsets to both planes, sign and magnitude split.
	always_comb begin
		logic signed [COORD_BITS-1:0] o, d, lo, hi;
		logic signed [COORD_BITS:0]   dl, dh;
		for (int a = 0; a < 3; a++) begin
			o  = coord(o_f[a]);
			d  = coord(d_f[a]);
			lo = coord(l_f[a]);
			hi = coord(h_f[a]);
			dl = {lo[COORD_BITS-1], lo} - {o[COORD_BITS-1], o};
			dh = {hi[COORD_BITS-1], hi} - {o[COORD_BITS-1], o};
			ax[a].par     = (d == '0);
			ax[a].pmiss   = (d == '0) && ((o < lo) || (o > hi));
			ax[a].dneg    = d[COORD_BITS-1];
			ax[a].neg_lo  = dl[COORD_BITS] ^ d[COORD_BITS-1];
			ax[a].neg_hi  = dh[COORD_BITS] ^ d[COORD_BITS-1];
			ax[a].amag_lo = dl[COORD_BITS] ? MW'(~dl + 1'b1) : MW'(dl);
			ax[a].amag_hi = dh[COORD_BITS] ? MW'(~dh + 1'b1) : MW'(dh);
			ax[a].dmag    = d[COORD_BITS-1] ? COORD_BITS'(~d + 1'b1) : COORD_BITS'(d);
		end
	end

	assign slab = ax;

endmodule

// ----- hdl/rbs_fifo.sv -----
// Small first-in first-out queue of registers with a fill count.
// Depends on nothing.
module rbs_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             wr_ok, rd_ok;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_ok = wr && !full;
	assign rd_ok = rd && !empty;
	assign rdata = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_ok)
				wp_q <= wp_q + 1'b1;
			if (rd_ok)
				rp_q <= rp_q + 1'b1;
			if (wr_ok && !rd_ok)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_ok && !wr_ok)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (wr_ok)
			mem_q[wp_q] <= wdata;
	end

endmodule

// ----- hdl/rbs_back.sv -----
// Back end: pipelined reciprocal divider, split multiplier, saturation and the
// entry and exit reduction over the three axes. Depends on rbs_pkg.
module rbs_back #(
	parameter int COORD_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            slab_valid,
	output logic                                            slab_pop,
	input  logic [3*rbs_pkg::slab_bits(COORD_BITS)-1:0]     slab,
	output logic                                            res_push,
	output rbs_pkg::result_t                                res,
	input  logic                                            res_full
);
	import rbs_pkg::*;

	localparam int MW  = COORD_BITS + 1;
	localparam int DW  = COORD_BITS;
	localparam int QW  = 2 * FRACTION_BITS + 1;
	localparam int LW  = (QW + 3) / 4;
	localparam int PPW = MW + LW;
	localparam int HSW = MW + 2 * LW + 1;
	localparam int SW  = MW + 4 * LW + 2;
	localparam int PXW = (SW > FRACTION_BITS + 32) ? SW : FRACTION_BITS + 32;
	localparam int TW  = DIST_BITS + 1;

	typedef struct packed {
		logic                  par;
		logic                  pmiss;
		logic                  dneg;
		logic                  neg_lo;
		logic                  neg_hi;
		logic [MW-1:0]         amag_lo;
		logic [MW-1:0]         amag_hi;
		logic [COORD_BITS-1:0] dmag;
	} slab_t;

	typedef struct packed {
		logic par;
		logic pmiss;
		logic dneg;
		logic neg_lo;
		logic neg_hi;
	} flag_t;

	logic adv;

	// The whole back end moves together whenever the result queue has room.
	assign adv      = !res_full;
	assign slab_pop = adv && slab_valid;

	// Reciprocal divider: one quotient bit per stage.
	logic [QW-1:0]           dv_v_s;
	slab_t [2:0]             dv_ax_s  [QW];
	logic [2:0][DW-1:0]      dv_rem_s [QW];
	logic [2:0][QW-1:0]      dv_q_s   [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s <= '0;
		else if (adv)
			dv_v_s <= {dv_v_s[QW-2:0], slab_valid};
	end

	for (genvar s = 0; s < QW; s++) begin : g_div
		slab_t [2:0]        ax_in;
		logic [2:0][DW-1:0] rem_in, rem_nx;
		logic [2:0][QW-1:0] q_in, q_nx;

		if (s == 0) begin : g_first
			assign ax_in  = slab;
			assign rem_in = '0;
			assign q_in   = '0;
		end else begin : g_next
			assign ax_in  = dv_ax_s[s-1];
			assign rem_in = dv_rem_s[s-1];
			assign q_in   = dv_q_s[s-1];
		end

		// The dividend is a single one at its top bit.
		always_comb begin
			logic [DW:0] trial;
			for (int a = 0; a < 3; a++) begin
				trial   = {rem_in[a], 1'(s == 0)};
				rem_nx[a] = trial[DW-1:0];
				q_nx[a]   = q_in[a];
				if (trial >= {1'b0, ax_in[a].dmag}) begin
					rem_nx[a]         = DW'(trial - {1'b0, ax_in[a].dmag});
					q_nx[a][QW-1-s]   = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ax_s[s]  <= ax_in;
				dv_rem_s[s] <= rem_nx;
				dv_q_s[s]   <= q_nx;
			end
		end
	end

	// Pipeline valid bits after the divider.
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= dv_v_s[QW-1];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Partial products of offset magnitude and reciprocal limbs.
	logic [2:0][3:0][PPW-1:0] pp_lo_s1, pp_hi_s1;
	flag_t [2:0]              fl_s1;

	always_ff @(posedge clk) begin
		logic [4*LW-1:0] r;
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				r = (4*LW)'(dv_q_s[QW-1][a]);
				fl_s1[a] <= '{par: dv_ax_s[QW-1][a].par, pmiss: dv_ax_s[QW-1][a].pmiss,
					dneg: dv_ax_s[QW-1][a].dneg, neg_lo: dv_ax_s[QW-1][a].neg_lo,
					neg_hi: dv_ax_s[QW-1][a].neg_hi};
				for (int j = 0; j < 4; j++) begin
					pp_lo_s1[a][j] <= PPW'(dv_ax_s[QW-1][a].amag_lo) * PPW'(r[j*LW +: LW]);
					pp_hi_s1[a][j] <= PPW'(dv_ax_s[QW-1][a].amag_hi) * PPW'(r[j*LW +: LW]);
				end
			end
		end
	end

	// Pairwise sums of the partial products.
	logic [2:0][1:0][HSW-1:0] hs_lo_s2, hs_hi_s2;
	flag_t [2:0]              fl_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s2 <= fl_s1;
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 2; k++) begin
					hs_lo_s2[a][k] <= HSW'(pp_lo_s1[a][2*k]) +
						(HSW'(pp_lo_s1[a][2*k+1]) << LW);
					hs_hi_s2[a][k] <= HSW'(pp_hi_s1[a][2*k]) +
						(HSW'(pp_hi_s1[a][2*k+1]) << LW);
				end
			end
		end
	end

	// Final sum, drop the fraction and saturate the magnitude.
	logic [2:0][DIST_BITS-1:0] mag_lo_s3, mag_hi_s3;
	flag_t [2:0]               fl_s3;

	function automatic logic [DIST_BITS-1:0] sat_mag(logic [1:0][HSW-1:0] h);
		logic [PXW-1:0] p;
		p = PXW'(SW'(h[0]) + (SW'(h[1]) << (2 * LW)));
		if (|p[PXW-1:FRACTION_BITS+DIST_BITS])
			return ENTRY_MAX;
		return p[FRACTION_BITS+DIST_BITS-1:FRACTION_BITS];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s3 <= fl_s2;
			for (int a = 0; a < 3; a++) begin
				mag_lo_s3[a] <= sat_mag(hs_lo_s2[a]);
				mag_hi_s3[a] <= sat_mag(hs_hi_s2[a]);
			end
		end
	end

	// Apply signs, order entry and exit, and neutralise parallel axes.
	// Each axis is kept as its own signed word so that comparisons stay signed.
	logic signed [TW-1:0] te_s4 [3];
	logic signed [TW-1:0] tl_s4 [3];
	logic                 pmiss_s4;

	always_ff @(posedge clk) begin
		logic signed [TW-1:0] dlo, dhi;
		if (adv) begin
			pmiss_s4 <= fl_s3[0].pmiss || fl_s3[1].pmiss || fl_s3[2].pmiss;
			for (int a = 0; a < 3; a++) begin
				dlo = fl_s3[a].neg_lo ? -{1'b0, mag_lo_s3[a]} : {1'b0, mag_lo_s3[a]};
				dhi = fl_s3[a].neg_hi ? -{1'b0, mag_hi_s3[a]} : {1'b0, mag_hi_s3[a]};
				if (fl_s3[a].par) begin
					te_s4[a] <= '0;
					tl_s4[a] <= {1'b0, ENTRY_MAX};
				end else if (fl_s3[a].dneg) begin
					te_s4[a] <= dhi;
					tl_s4[a] <= dlo;
				end else begin
					te_s4[a] <= dlo;
					tl_s4[a] <= dhi;
				end
			end
		end
	end

	// Latest entry against earliest exit; the result queue holds the outcome.
	always_comb begin
		logic signed [TW-1:0] t, x;
		t = '0;
		x = {1'b0, ENTRY_MAX};
		for (int a = 0; a < 3; a++) begin
			if (te_s4[a] > t)
				t = te_s4[a];
			if (tl_s4[a] < x)
				x = tl_s4[a];
		end
		res.hit            = !pmiss_s4 && !(x < t);
		res.entry_distance = res.hit ? t[DIST_BITS-1:0] : '0;
	end

	assign res_push = v_s4 && adv;

endmodule

// ----- hdl/ray_box_slab_test.sv -----
// Ray against axis-aligned box test by the slab method, signed fixed point with
// FRACTION_BITS fraction bits. Rays enter through a queue interface (push/full)
// and one result per ray leaves through another (empty/pop), in order. A new ray
// is taken every cycle unless the queue between front and back is full, which
// happens when the result queue stalls the back end, and results can be drained
// every cycle. A ray passes through the queue between front and back, then
// 2*FRACTION_BITS+1 reciprocal divider stages that each resolve one quotient
// bit, three multiply and saturate stages, one sign stage and the result queue.
// Depends on rbs_pkg, rbs_front, rbs_fifo and rbs_back.
module ray_box_slab_test #(
	parameter int COORD_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rbs_pkg::ray_t    ray,
	output logic             empty,
	input  logic             pop,
	output rbs_pkg::result_t result
);
	import rbs_pkg::*;

	localparam int SLW = 3 * slab_bits(COORD_BITS);

	logic [SLW-1:0] slab_in, slab_out;
	logic           mid_empty, slab_pop;
	logic           res_push, res_full;
	result_t        res;

	// Front end classifies the incoming transaction.
	rbs_front #(.COORD_BITS(COORD_BITS)) u_front (
		.ray  (ray),
		.slab (slab_in)
	);

	// Queue between front and back.
	rbs_fifo #(.WIDTH(SLW), .DEPTH(4)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (slab_in),
		.full   (full),
		.rd     (slab_pop),
		.rdata  (slab_out),
		.empty  (mid_empty)
	);

	rbs_back #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slab_valid (!mid_empty),
		.slab_pop   (slab_pop),
		.slab       (slab_out),
		.res_push   (res_push),
		.res        (res),
		.res_full   (res_full)
	);

	// Result queue decouples the pipeline from the consumer.
	rbs_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res),
		.full   (res_full),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

// ----- hdl/rbs_checker.sv -----
// Port level checks for the slab test, attached to the top level by bind.
// Depends on rbs_pkg and ray_box_slab_test.
module rbs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input rbs_pkg::result_t result
);
	import rbs_pkg::*;

	logic [7:0] outstanding_q;

	// Transactions accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if ((push && !full) && !(pop && !empty))
			outstanding_q <= outstanding_q + 1'b1;
		else if (!(push && !full) && (pop && !empty))
			outstanding_q <= outstanding_q - 1'b1;
	end

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.hit || result.entry_distance == '0))
		else $error("miss reported with a nonzero entry distance");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> outstanding_q != '0)
		else $error("result shown with no transaction outstanding");

	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> outstanding_q != '0)
		else $error("full raised with nothing in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

endmodule

bind ray_box_slab_test rbs_checker u_rbs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
